// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

// ===== rtl/ircf_pkg.sv =====
// Types, constants and code tables of the climate frame encoder.
`timescale 1ns / 1ps
`default_nettype none
package ircf_pkg;

    localparam int FRAME_LEN  = 18;
    localparam int TICK_W     = 15;
    localparam int IDX_W      = 5;                 // result index 0..19
    localparam int BYTE_IDX_W = 5;                 // frame byte 0..17
    localparam logic [IDX_W-1:0] SYM_LAST = 5'd19; // trailer position
    localparam logic [TICK_W-1:0] TICK_MAX = 15'h7FFF;

    localparam logic [7:0] FRAME_TEMPLATE [FRAME_LEN] = '{
        8'h23, 8'hCB, 8'h26, 8'h01, 8'h00, 8'h20, 8'h08, 8'h06, 8'h30,
        8'h45, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1F
    };

    // Patched byte positions
    localparam logic [BYTE_IDX_W-1:0] POS_POWER = 5'd5;
    localparam logic [BYTE_IDX_W-1:0] POS_MODE  = 5'd6;
    localparam logic [BYTE_IDX_W-1:0] POS_TEMP  = 5'd7;
    localparam logic [BYTE_IDX_W-1:0] POS_FAN   = 5'd9;
    localparam logic [BYTE_IDX_W-1:0] POS_CHK   = 5'd17;

    // Sum of the template bytes that are never patched (0..16 less 5,6,7,9)
    localparam logic [7:0] CHK_BASE = 8'(
        FRAME_TEMPLATE[0] + FRAME_TEMPLATE[1] + FRAME_TEMPLATE[2] +
        FRAME_TEMPLATE[3] + FRAME_TEMPLATE[4] + FRAME_TEMPLATE[8] +
        FRAME_TEMPLATE[10] + FRAME_TEMPLATE[11] + FRAME_TEMPLATE[12] +
        FRAME_TEMPLATE[13] + FRAME_TEMPLATE[14] + FRAME_TEMPLATE[15] +
        FRAME_TEMPLATE[16]);

    localparam logic signed [7:0] TEMP_MIN = 8'sd16;
    localparam logic signed [7:0] TEMP_MAX = 8'sd31;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_TRAILER = 2'd2
    } t_sym_kind;

    typedef enum logic [2:0] {
        REG_HEADER_MARK   = 3'd0,
        REG_HEADER_SPACE  = 3'd1,
        REG_BIT_MARK      = 3'd2,
        REG_ONE_SPACE     = 3'd3,
        REG_ZERO_SPACE    = 3'd4,
        REG_TRAILER_MARK  = 3'd5,
        REG_TRAILER_SPACE = 3'd6
    } t_cfg_reg;

    localparam logic [3:0] COUNT_SINGLE = 4'd1;
    localparam logic [3:0] COUNT_BYTE   = 4'd8;

    // Command-dependent bytes of one frame
    typedef struct packed {
        logic [7:0] power;
        logic [7:0] mode;
        logic [7:0] temp;
        logic [7:0] fan_vane;
        logic [7:0] chk;
    } t_frame_var;

    // Mark plus space, saturated
    function automatic logic [TICK_W-1:0] sat_period(input logic [TICK_W-1:0] mark,
                                                      input logic [TICK_W-1:0] space);
        logic [TICK_W:0] s;
        s = {1'b0, mark} + {1'b0, space};
        return s[TICK_W] ? TICK_MAX : s[TICK_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ircf_frame_builder.sv =====
// Patches one command into the frame template and forms the checksum.
`timescale 1ns / 1ps
`default_nettype none
module ircf_frame_builder
    import ircf_pkg::*;
(
    input  wire logic              i_power_off,
    input  wire logic [1:0]        i_mode,
    input  wire logic signed [7:0] i_temperature,
    input  wire logic [2:0]        i_fan_speed,
    input  wire logic [2:0]        i_vane_position,
    output t_frame_var             o_var
);

    logic [7:0] power_b, mode_b, temp_b, fan_b, vane_b, fv_b;

    always_comb begin
        power_b = i_power_off ? 8'h00 : 8'h20;

        unique case (i_mode)
            2'd0: mode_b = 8'h08;
            2'd1: mode_b = 8'h18;
            2'd2: mode_b = 8'h10;
            2'd3: mode_b = 8'h20;
            default: mode_b = 8'h08;
        endcase

        // clamp to 16..31, stored minus 16
        if (i_temperature > TEMP_MAX) begin
            temp_b = 8'h0F;
        end else if (i_temperature < TEMP_MIN) begin
            temp_b = 8'h00;
        end else begin
            temp_b = {4'h0, i_temperature[3:0]};
        end

        unique case (i_fan_speed)
            3'd0: fan_b = 8'h01;
            3'd1: fan_b = 8'h02;
            3'd2: fan_b = 8'h03;
            3'd3: fan_b = 8'h04;
            3'd4: fan_b = 8'h04;
            3'd5: fan_b = 8'h80;
            3'd6: fan_b = 8'h05;
            3'd7: fan_b = FRAME_TEMPLATE[POS_FAN];
            default: fan_b = FRAME_TEMPLATE[POS_FAN];
        endcase

        unique case (i_vane_position)
            3'd0: vane_b = 8'h40;
            3'd1: vane_b = 8'h48;
            3'd2: vane_b = 8'h50;
            3'd3: vane_b = 8'h58;
            3'd4: vane_b = 8'h60;
            3'd5: vane_b = 8'h68;
            3'd6: vane_b = 8'h78;
            3'd7: vane_b = 8'h00;
            default: vane_b = 8'h00;
        endcase

        fv_b = fan_b | vane_b;

        o_var.power    = power_b;
        o_var.mode     = mode_b;
        o_var.temp     = temp_b;
        o_var.fan_vane = fv_b;
        o_var.chk      = CHK_BASE + power_b + mode_b + temp_b + fv_b;
    end

endmodule
`default_nettype wire

// ===== rtl/ir_climate_frame_encoder.sv =====
// Top level of the climate frame encoder: command in, 20 pulse-distance results out.
// A command transfer sets the busy flag; the header result is then registered for m_axis.
// One result per cycle unless m_axis_tready stalls; the result counter walks the frame.
// A new command is taken in the cycle its predecessor's trailer enters the output register.
// Reset (synchronous, active low) clears control state and loads the timing defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ir_climate_frame_encoder
    import ircf_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // configuration write channel
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [14:0]   i_cfg_data,
    // command stream
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [0] power_off, [2:1] mode, [10:3] temperature, [13:11] fan_speed,
    // [16:14] vane_position, [23:17] zero
    input  wire logic [23:0]   s_axis_tdata,
    // result stream
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [3:0] symbol_count, [18:4] mark_length, [33:19] period_0, [48:34] period_1,
    // [63:49] period_2, [78:64] period_3, [93:79] period_4, [108:94] period_5,
    // [123:109] period_6, [138:124] period_7, [143:139] zero
    output logic [143:0]       m_axis_tdata,
    // [1:0] symbol_kind
    output logic [1:0]         m_axis_tuser,
    output logic               m_axis_tlast         // last_result
);

    // ---------------- timing registers ----------------
    logic [TICK_W-1:0] r_header_mark, r_header_space, r_bit_mark, r_one_space;
    logic [TICK_W-1:0] r_zero_space, r_trailer_mark, r_trailer_space;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_mark   <= 15'd3400;
            r_header_space  <= 15'd1750;
            r_bit_mark      <= 15'd450;
            r_one_space     <= 15'd1300;
            r_zero_space    <= 15'd420;
            r_trailer_mark  <= 15'd440;
            r_trailer_space <= 15'd17100;
        end else if (i_cfg_valid) begin
            // indices beyond the list are dropped
            unique case (t_cfg_reg'(i_cfg_index))
                REG_HEADER_MARK:   r_header_mark   <= i_cfg_data;
                REG_HEADER_SPACE:  r_header_space  <= i_cfg_data;
                REG_BIT_MARK:      r_bit_mark      <= i_cfg_data;
                REG_ONE_SPACE:     r_one_space     <= i_cfg_data;
                REG_ZERO_SPACE:    r_zero_space    <= i_cfg_data;
                REG_TRAILER_MARK:  r_trailer_mark  <= i_cfg_data;
                REG_TRAILER_SPACE: r_trailer_space <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- frame build at command transfer ----------------
    t_frame_var cmd_var;

    ircf_frame_builder u_builder (
        .i_power_off     (s_axis_tdata[0]),
        .i_mode          (s_axis_tdata[2:1]),
        .i_temperature   (s_axis_tdata[10:3]),
        .i_fan_speed     (s_axis_tdata[13:11]),
        .i_vane_position (s_axis_tdata[16:14]),
        .o_var           (cmd_var)
    );

    logic             r_busy, n_busy;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_frame_var       r_var;

    // output register
    logic              r_out_valid, n_out_valid;
    t_sym_kind         r_kind, n_kind;
    logic [3:0]        r_count, n_count;
    logic [TICK_W-1:0] r_mark, n_mark;
    logic [TICK_W-1:0] r_period [8];
    logic [TICK_W-1:0] n_period [8];
    logic              r_last, n_last;

    logic                  emit, in_xfer;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [7:0]            cur_byte;
    logic [TICK_W-1:0]     one_p, zero_p, hdr_p, trl_p;

    // the output register can take a result when empty or being drained
    assign emit          = r_busy && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_busy || (emit && (r_idx == SYM_LAST));
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign one_p  = sat_period(r_bit_mark, r_one_space);
    assign zero_p = sat_period(r_bit_mark, r_zero_space);
    assign hdr_p  = sat_period(r_header_mark, r_header_space);
    assign trl_p  = sat_period(r_trailer_mark, r_trailer_space);

    // data results sit at indices 1..18, frame bytes 0..17
    assign byte_idx = r_idx - 5'd1;

    always_comb begin
        unique case (byte_idx)
            POS_POWER: cur_byte = r_var.power;
            POS_MODE:  cur_byte = r_var.mode;
            POS_TEMP:  cur_byte = r_var.temp;
            POS_FAN:   cur_byte = r_var.fan_vane;
            POS_CHK:   cur_byte = r_var.chk;
            default: begin
                if (byte_idx < POS_CHK) begin
                    cur_byte = FRAME_TEMPLATE[byte_idx];
                end else begin
                    cur_byte = 8'h00;
                end
            end
        endcase
    end

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_kind      = r_kind;
        n_count     = r_count;
        n_mark      = r_mark;
        n_period    = r_period;
        n_last      = r_last;

        if (emit) begin
            n_out_valid = 1'b1;
            for (int k = 0; k < 8; k++) begin
                n_period[k] = '0;
            end
            if (r_idx == '0) begin
                n_kind      = KIND_HEADER;
                n_count     = COUNT_SINGLE;
                n_mark      = r_header_mark;
                n_period[0] = hdr_p;
                n_last      = 1'b0;
            end else if (r_idx == SYM_LAST) begin
                n_kind      = KIND_TRAILER;
                n_count     = COUNT_SINGLE;
                n_mark      = r_trailer_mark;
                n_period[0] = trl_p;
                n_last      = 1'b1;
            end else begin
                n_kind  = KIND_DATA;
                n_count = COUNT_BYTE;
                n_mark  = r_bit_mark;
                n_last  = 1'b0;
                for (int k = 0; k < 8; k++) begin
                    n_period[k] = cur_byte[k] ? one_p : zero_p;
                end
            end
            if (r_idx == SYM_LAST) begin
                n_idx  = '0;
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 5'd1;
            end
        end

        if (in_xfer) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_count  <= n_count;
        r_mark   <= n_mark;
        r_period <= n_period;
        r_last   <= n_last;
        if (in_xfer) begin
            r_var <= cmd_var;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {5'd0, r_period[7], r_period[6], r_period[5], r_period[4],
                            r_period[3], r_period[2], r_period[1], r_period[0],
                            r_mark, r_count};

    // ---------------- assertions ----------------
    `ASSERT_IMPL(a_idle_idx_zero, i_clk, i_rst_n, !r_busy, r_idx == '0)
    `ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= SYM_LAST)
    `ASSERT_NEXT(a_xfer_busy, i_clk, i_rst_n, in_xfer, r_busy)
    `ASSERT_IMPL(a_last_is_trailer, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast,
                 m_axis_tuser == KIND_TRAILER)

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the climate frame encoder: commands in, pulse schedules checked.
`timescale 1ns / 1ps
module tb;
    import ircf_pkg::*;

    // ---------------------------------------------------------------
    // Run limits and local codes
    // ---------------------------------------------------------------
    localparam int CYCLE_LIMIT  = 1_000_000;   // far beyond the slowest legal run
    localparam int REPORT_LIMIT = 10;          // mismatches printed in full
    localparam int HOLD_CYCLES  = 400;         // long receiver hold-off
    localparam logic [2:0] CFG_IDX_SPARE = 3'd7;   // no register here, write is dropped

    // Command and frame constants (own copy, used by the predictor)
    localparam logic [17:0][7:0] FRAME_BASE = {
        8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h67, 8'h45,
        8'h30, 8'h06, 8'h08, 8'h20, 8'h00, 8'h01, 8'h26, 8'hCB, 8'h23
    };
    localparam logic [3:0][7:0] MODE_BYTE = {8'h20, 8'h10, 8'h18, 8'h08};
    localparam logic [6:0][7:0] FAN_BYTE  = {8'h05, 8'h80, 8'h04, 8'h04, 8'h03, 8'h02, 8'h01};
    localparam logic [6:0][7:0] VANE_BITS = {8'h78, 8'h68, 8'h60, 8'h58, 8'h50, 8'h48, 8'h40};
    localparam logic [7:0] POWER_ON_BYTE = 8'h20;
    localparam logic [7:0] POWER_OFF_BYTE = 8'h00;
    localparam logic [2:0] CODE_KEEP = 3'd7;    // fan or vane code that leaves byte 9 alone
    localparam int TEMP_FLOOR = 16;
    localparam int TEMP_CEIL  = 31;
    localparam int FRAME_BYTES = 18;

    // One command; last field lands in the lowest bits of tdata
    typedef struct packed {
        logic [2:0] vane;
        logic [2:0] fan;
        logic [7:0] temp;
        logic [1:0] mode;
        logic       power_off;
    } climate_cmd_t;

    // One result of the pulse schedule
    typedef struct packed {
        t_sym_kind        kind;
        logic [3:0]       count;
        logic [14:0]      mark;
        logic [7:0][14:0] periods;
        logic             last;
    } pulse_sym_t;

    // ---------------------------------------------------------------
    // DUT connections
    // ---------------------------------------------------------------
    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [14:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    ir_climate_frame_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ---------------------------------------------------------------
    // Predictor state and scoreboard
    // ---------------------------------------------------------------
    logic [14:0] timing [7];            // shadow of the timing registers
    pulse_sym_t  pending_syms [$];      // expected results, oldest first

    int send_gap_pct;                   // chance per cycle that the sender idles
    int recv_gap_pct;                   // chance per cycle that the receiver stalls
    int hold_left;                      // receiver hold-off cycles still to run

    int fail_count;
    int mismatch_count;
    int cmds_sent;
    int syms_checked;
    int cfg_writes;
    int input_stalls;                   // cycles the encoder refused an offered command

    // ---------------------------------------------------------------
    // Clock, cycle limit
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void load_default_timing();
        timing[REG_HEADER_MARK]   = 15'd3400;
        timing[REG_HEADER_SPACE]  = 15'd1750;
        timing[REG_BIT_MARK]      = 15'd450;
        timing[REG_ONE_SPACE]     = 15'd1300;
        timing[REG_ZERO_SPACE]    = 15'd420;
        timing[REG_TRAILER_MARK]  = 15'd440;
        timing[REG_TRAILER_SPACE] = 15'd17100;
    endfunction

    // Mark plus space, clipped to the 15-bit tick range
    function automatic logic [14:0] clipped_period(logic [14:0] mark, logic [14:0] space);
        logic [15:0] total;
        total = {1'b0, mark} + {1'b0, space};
        return total[15] ? 15'h7FFF : total[14:0];
    endfunction

    function automatic logic [17:0][7:0] climate_frame(climate_cmd_t cmd);
        logic [17:0][7:0] frame;
        int               t;
        logic [7:0]       sum;
        frame    = FRAME_BASE;
        frame[5] = cmd.power_off ? POWER_OFF_BYTE : POWER_ON_BYTE;
        frame[6] = MODE_BYTE[cmd.mode];
        t = $signed(cmd.temp);
        if (t > TEMP_CEIL)
            t = TEMP_CEIL;
        if (t < TEMP_FLOOR)
            t = TEMP_FLOOR;
        frame[7] = 8'(t - TEMP_FLOOR);
        if (cmd.fan != CODE_KEEP)
            frame[9] = FAN_BYTE[cmd.fan];
        if (cmd.vane != CODE_KEEP)
            frame[9] = frame[9] | VANE_BITS[cmd.vane];
        sum = 8'd0;
        for (int b = 0; b < FRAME_BYTES - 1; b++)
            sum = sum + frame[b];
        frame[FRAME_BYTES-1] = sum;
        return frame;
    endfunction

    // Queue the twenty results that one accepted command must produce
    function automatic void predict_schedule(climate_cmd_t cmd);
        logic [17:0][7:0] frame;
        pulse_sym_t       sym;
        logic [14:0]      one_p;
        logic [14:0]      zero_p;
        frame = climate_frame(cmd);
        one_p  = clipped_period(timing[REG_BIT_MARK], timing[REG_ONE_SPACE]);
        zero_p = clipped_period(timing[REG_BIT_MARK], timing[REG_ZERO_SPACE]);

        sym            = '0;
        sym.kind       = KIND_HEADER;
        sym.count      = COUNT_SINGLE;
        sym.mark       = timing[REG_HEADER_MARK];
        sym.periods[0] = clipped_period(timing[REG_HEADER_MARK], timing[REG_HEADER_SPACE]);
        pending_syms.push_back(sym);

        for (int b = 0; b < FRAME_BYTES; b++) begin
            sym       = '0;
            sym.kind  = KIND_DATA;
            sym.count = COUNT_BYTE;
            sym.mark  = timing[REG_BIT_MARK];
            for (int k = 0; k < 8; k++)
                sym.periods[k] = frame[b][k] ? one_p : zero_p;
            pending_syms.push_back(sym);
        end

        sym            = '0;
        sym.kind       = KIND_TRAILER;
        sym.count      = COUNT_SINGLE;
        sym.mark       = timing[REG_TRAILER_MARK];
        sym.periods[0] = clipped_period(timing[REG_TRAILER_MARK], timing[REG_TRAILER_SPACE]);
        sym.last       = 1'b1;
        pending_syms.push_back(sym);
    endfunction

    // ---------------------------------------------------------------
    // Result checker: one transfer per rising edge at most
    // ---------------------------------------------------------------
    task automatic check_field(string name, int idx, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("tb: result %0d %s mismatch: expected %0d, got %0d",
                         idx, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        pulse_sym_t want;
        if (i_rst_n && s_axis_tvalid && !s_axis_tready)
            input_stalls++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_syms.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("tb: result %0d arrived with nothing expected", syms_checked);
            end else begin
                want = pending_syms.pop_front();
                check_field("symbol_kind", syms_checked, want.kind, m_axis_tuser);
                check_field("symbol_count", syms_checked, want.count, m_axis_tdata[3:0]);
                check_field("mark_length", syms_checked, want.mark, m_axis_tdata[18:4]);
                for (int k = 0; k < 8; k++)
                    check_field($sformatf("period_%0d", k), syms_checked, want.periods[k],
                                m_axis_tdata[19 + 15*k +: 15]);
                check_field("last_result", syms_checked, want.last, m_axis_tlast);
            end
            syms_checked++;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left      = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers (called at a falling edge, return at one)
    // ---------------------------------------------------------------
    task automatic send_command(climate_cmd_t cmd);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_schedule(cmd);
        cmds_sent++;
        @(negedge i_clk);
    endtask

    // Let every expected result arrive, then a few spare cycles
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_syms.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [14:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= REG_TRAILER_SPACE)
            timing[idx] = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all_regs(logic [14:0] value);
        for (int r = REG_HEADER_MARK; r <= REG_TRAILER_SPACE; r++)
            write_reg(3'(r), value);
    endtask

    function automatic logic [14:0] random_ticks();
        case ($urandom_range(0, 3))
            0: return 15'($urandom_range(0, 32767));
            1: return 15'($urandom_range(0, 2000));
            2: return 15'($urandom_range(32000, 32767));
            default: return 15'($urandom_range(100, 1500));
        endcase
    endfunction

    // Temperatures mostly near the usable band, sometimes anywhere in the byte
    function automatic climate_cmd_t random_command();
        climate_cmd_t cmd;
        cmd.power_off = 1'($urandom_range(0, 1));
        cmd.mode      = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
            cmd.temp = 8'($urandom_range(0, 255));
        else
            cmd.temp = 8'($urandom_range(10, 40));
        cmd.fan  = 3'($urandom_range(0, 7));
        cmd.vane = 3'($urandom_range(0, 7));
        return cmd;
    endfunction

    function automatic climate_cmd_t make_cmd(logic pwr, logic [1:0] md, int temp,
                                              logic [2:0] fan, logic [2:0] vane);
        climate_cmd_t cmd;
        cmd.power_off = pwr;
        cmd.mode      = md;
        cmd.temp      = 8'(temp);
        cmd.fan       = fan;
        cmd.vane      = vane;
        return cmd;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Default timing; every mode, fan and vane code, clamp edges, full byte range
    task automatic test_directed_codes();
        send_command(make_cmd(1'b0, 2'd0, 24, 3'd0, 3'd0));
        send_command(make_cmd(1'b1, 2'd1, 16, 3'd1, 3'd1));
        send_command(make_cmd(1'b0, 2'd2, 31, 3'd2, 3'd2));
        send_command(make_cmd(1'b1, 2'd3, 15, 3'd3, 3'd3));
        send_command(make_cmd(1'b0, 2'd0, -128, 3'd4, 3'd4));
        send_command(make_cmd(1'b1, 2'd1, 127, 3'd5, 3'd5));
        send_command(make_cmd(1'b0, 2'd2, 32, 3'd6, 3'd6));
        send_command(make_cmd(1'b1, 2'd3, 0, 3'd7, 3'd7));   // byte 9 untouched
        send_command(make_cmd(1'b0, 2'd1, -1, 3'd7, 3'd0));  // template fan, vane ORed
        send_command(make_cmd(1'b1, 2'd0, 20, 3'd0, 3'd7));  // fan only
        send_command(make_cmd(1'b0, 2'd3, 22, 3'd5, 3'd6));
        drain();
    endtask

    // All registers at the top (every period clips), at zero, then sums near the top and the spare index
    task automatic test_timing_extremes();
        write_all_regs(15'h7FFF);
        for (int n = 0; n < 6; n++)
            send_command(random_command());
        drain();
        write_all_regs(15'd0);
        for (int n = 0; n < 6; n++)
            send_command(random_command());
        drain();
        // Sum just past the top on the one-bit and trailer periods, just inside on the header
        write_reg(REG_HEADER_MARK, 15'd16384);
        write_reg(REG_HEADER_SPACE, 15'd16383);
        write_reg(REG_BIT_MARK, 15'd16384);
        write_reg(REG_ONE_SPACE, 15'd16384);
        write_reg(REG_ZERO_SPACE, 15'd1);
        write_reg(REG_TRAILER_MARK, 15'd1);
        write_reg(REG_TRAILER_SPACE, 15'd32767);
        write_reg(CFG_IDX_SPARE, 15'h5A5A);                 // must change nothing
        for (int n = 0; n < 6; n++)
            send_command(random_command());
        drain();
    endtask

    // Random commands under one idling profile, fresh random timing first
    task automatic test_random_commands(int n_cmds, int s_pct, int r_pct);
        send_gap_pct = s_pct;
        recv_gap_pct = r_pct;
        for (int r = REG_HEADER_MARK; r <= REG_TRAILER_SPACE; r++)
            write_reg(3'(r), random_ticks());
        for (int n = 0; n < n_cmds; n++) begin
            // retune one register halfway so the second half may see different settings
            if (n == n_cmds / 2) begin
                drain();
                write_reg(3'($urandom_range(REG_HEADER_MARK, REG_TRAILER_SPACE)),
                          random_ticks());
            end
            send_command(random_command());
        end
        drain();
    endtask

    // Receiver stops for a long stretch while commands keep coming: input must back up
    task automatic test_output_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        @(negedge i_clk);
        for (int n = 0; n < 8; n++)
            send_command(random_command());
        drain();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        send_gap_pct  = 8;
        recv_gap_pct  = 69;
        hold_left     = 0;
        fail_count     = 0;
        mismatch_count = 0;
        cmds_sent      = 0;
        syms_checked   = 0;
        cfg_writes     = 0;
        input_stalls   = 0;
        load_default_timing();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_codes();
        test_timing_extremes();
        test_random_commands(75, 8, 69);
        test_random_commands(75, 69, 8);
        test_random_commands(75, 0, 0);
        test_output_backpressure();

        repeat (30) @(posedge i_clk);
        if (pending_syms.size() != 0) begin
            fail_count += pending_syms.size();
            $display("tb: %0d expected results never arrived", pending_syms.size());
        end

        $display("tb: %0d commands, %0d results checked, %0d register writes (extremes,",
                 cmds_sent, syms_checked, cfg_writes);
        $display("tb: spare index, random), %0d input stall cycles, %0d mismatches",
                 input_stalls, mismatch_count);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
